FILE: rtl/bucketed_index_set_swap_remove_macros.svh
// Assertion macros shared by the bucketed index set RTL.
`ifndef BUCKETED_INDEX_SET_SWAP_REMOVE_MACROS_SVH
`define BUCKETED_INDEX_SET_SWAP_REMOVE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BISR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BISR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

FILE: rtl/bisr_pkg.sv
// Package with the opcodes, status codes and default sizes of the bucketed index set.
package bisr_pkg;

   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int RANDOM_W = 16;

   localparam int DEFAULT_MAX_ELEMENTS = 1024;
   localparam int DEFAULT_NUM_CLASSES  = 16;

   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_MOVE   = 3'd2;
   localparam logic [OP_W-1:0] OP_PICK   = 3'd3;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;
   localparam logic [OP_W-1:0] OP_COUNT  = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd3;

endpackage

FILE: rtl/bucketed_index_set_swap_remove.sv
// Bucketed index set: element ids kept in per-class dense lists with swap-remove moves.
//
// A request transaction carries an opcode and its operands on the req_ channel; every
// request yields exactly one response transaction on the rsp_ channel, in order.
// The block handles one request at a time. It takes a request only while no earlier
// request is still in flight, but a finished response may still sit in the output
// register waiting for the receiver when the next request is accepted.
// A response is registered from ST_EXEC for clear, count, insert and the error cases,
// from ST_RDATA after ST_EXEC for pick and lookup, and from ST_MOVE2 after ST_EXEC and
// ST_MOVE1 for move. These steps are set by the single-ported element and bucket
// memories: a move reads the element entry as the request is accepted, reads the last
// entry of the old bucket, then writes the element and bucket memories twice in turn.
// While rsp_stall holds a response, a request that has reached its result step waits
// there without touching any state, and req_stall stays high.
// Reset clears the bucket counts, the id counter and all handshake state. The element
// and bucket memories are not cleared; only entries already written are ever read.

`include "bucketed_index_set_swap_remove_macros.svh"

module bucketed_index_set_swap_remove #(
   parameter int MAX_ELEMENTS = bisr_pkg::DEFAULT_MAX_ELEMENTS,
   parameter int NUM_CLASSES  = bisr_pkg::DEFAULT_NUM_CLASSES,
   localparam int ID_W  = $clog2(MAX_ELEMENTS),
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
   localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bisr_pkg::OP_W-1:0]     req_opcode,
   input  logic [ID_W-1:0]               req_element_id,
   input  logic [CLS_W-1:0]              req_class_index,
   input  logic [ID_W-1:0]               req_position,
   input  logic [bisr_pkg::RANDOM_W-1:0] req_random_word,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ID_W-1:0]               rsp_element_out,
   output logic [CNT_W-1:0]              rsp_count_out,
   output logic [bisr_pkg::STATUS_W-1:0] rsp_status
);

   localparam int ELEM_W    = CLS_W + ID_W;
   localparam int BK_AW     = CLS_W + ID_W;
   localparam int BK_DEPTH  = NUM_CLASSES * (2 ** ID_W);
   localparam int PROD_W    = bisr_pkg::RANDOM_W + CNT_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_RDATA = 3'd2;
   localparam logic [2:0] ST_MOVE1 = 3'd3;
   localparam logic [2:0] ST_MOVE2 = 3'd4;

   // Control state.
   logic [2:0]       state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] bucket_count_ff [NUM_CLASSES];

   // Captured request and move scratch registers.
   logic [bisr_pkg::OP_W-1:0]     op_ff;
   logic [ID_W-1:0]               eid_ff;
   logic [CLS_W-1:0]              cls_ff;
   logic [ID_W-1:0]               pos_ff;
   logic [bisr_pkg::RANDOM_W-1:0] rnd_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [CLS_W-1:0]              old_ff, old_in;
   logic [ID_W-1:0]               opos_ff, opos_in;
   logic [CNT_W-1:0]              ocnt_ff, ocnt_in;

   // Response payload registers.
   logic [ID_W-1:0]               rsp_elem_ff, rsp_elem_in;
   logic [CNT_W-1:0]              rsp_cnt_ff, rsp_cnt_in;
   logic [bisr_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // Memories.
   logic [ELEM_W-1:0] elem_mem [MAX_ELEMENTS];
   logic [ID_W-1:0]   bucket_mem [BK_DEPTH];
   logic [ELEM_W-1:0] elem_rdata_ff;
   logic [ID_W-1:0]   bk_rdata_ff;

   logic              elem_we;
   logic [ID_W-1:0]   elem_waddr;
   logic [ELEM_W-1:0] elem_wdata;
   logic              bk_re;
   logic [BK_AW-1:0]  bk_raddr;
   logic              bk_we;
   logic [BK_AW-1:0]  bk_waddr;
   logic [ID_W-1:0]   bk_wdata;

   // Bucket count port: one read address per cycle, one write or a full clear.
   logic [CLS_W-1:0] cnt_raddr;
   logic             cnt_rok;
   logic [CNT_W-1:0] cnt_rdata;
   logic             cnt_we;
   logic [CLS_W-1:0] cnt_waddr;
   logic [CNT_W-1:0] cnt_wdata;
   logic             cnt_clr;

   logic             accept;
   logic             out_free;
   logic [PROD_W-1:0] pick_prod;
   logic [ID_W-1:0]  pick_pos;
   logic [CLS_W-1:0] old_cls;
   logic [ID_W-1:0]  old_pos;
   logic [ID_W-1:0]  back_id;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_element_out = rsp_elem_ff;
   assign rsp_count_out   = rsp_cnt_ff;
   assign rsp_status      = rsp_status_ff;

   assign pick_prod = PROD_W'(rnd_ff) * PROD_W'(cnt_ff);
   assign pick_pos  = pick_prod[bisr_pkg::RANDOM_W +: ID_W];
   assign old_cls   = elem_rdata_ff[ELEM_W-1 -: CLS_W];
   assign old_pos   = elem_rdata_ff[ID_W-1:0];
   assign back_id   = bk_rdata_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            cnt_raddr = req_class_index;
            cnt_rok   = (int'(req_class_index) < NUM_CLASSES);
         end
         ST_EXEC: begin
            cnt_raddr = old_cls;
            cnt_rok   = (int'(old_cls) < NUM_CLASSES);
         end
         default: begin
            cnt_raddr = cls_ff;
            cnt_rok   = (int'(cls_ff) < NUM_CLASSES);
         end
      endcase
      cnt_rdata = cnt_rok ? bucket_count_ff[cnt_raddr] : '0;
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_elem_in   = rsp_elem_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_status_in = rsp_status_ff;
      total_in      = total_ff;
      old_in        = old_ff;
      opos_in       = opos_ff;
      ocnt_in       = ocnt_ff;
      elem_we       = 1'b0;
      elem_waddr    = '0;
      elem_wdata    = '0;
      bk_re         = 1'b0;
      bk_raddr      = '0;
      bk_we         = 1'b0;
      bk_waddr      = '0;
      bk_wdata      = '0;
      cnt_we        = 1'b0;
      cnt_waddr     = '0;
      cnt_wdata     = '0;
      cnt_clr       = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_elem_in   = '0;
               rsp_cnt_in    = cnt_ff;
               rsp_status_in = bisr_pkg::STATUS_OK;
               if (op_ff == bisr_pkg::OP_CLEAR) begin
                  cnt_clr    = 1'b1;
                  total_in   = '0;
                  rsp_cnt_in = '0;
               end else if (op_ff > bisr_pkg::OP_COUNT || int'(cls_ff) >= NUM_CLASSES) begin
                  rsp_cnt_in    = '0;
                  rsp_status_in = bisr_pkg::STATUS_BAD_INDEX;
               end else begin
                  case (op_ff)
                     bisr_pkg::OP_INSERT: begin
                        if (total_ff >= CNT_W'(MAX_ELEMENTS)
                            || cnt_ff >= CNT_W'(MAX_ELEMENTS)) begin
                           rsp_status_in = bisr_pkg::STATUS_FULL;
                        end else begin
                           elem_we     = 1'b1;
                           elem_waddr  = total_ff[ID_W-1:0];
                           elem_wdata  = {cls_ff, cnt_ff[ID_W-1:0]};
                           bk_we       = 1'b1;
                           bk_waddr    = {cls_ff, cnt_ff[ID_W-1:0]};
                           bk_wdata    = total_ff[ID_W-1:0];
                           cnt_we      = 1'b1;
                           cnt_waddr   = cls_ff;
                           cnt_wdata   = cnt_ff + CNT_W'(1);
                           total_in    = total_ff + CNT_W'(1);
                           rsp_elem_in = total_ff[ID_W-1:0];
                           rsp_cnt_in  = cnt_ff + CNT_W'(1);
                        end
                     end
                     bisr_pkg::OP_MOVE: begin
                        if (CNT_W'(eid_ff) >= total_ff || int'(old_cls) >= NUM_CLASSES
                            || cnt_rdata == '0 || CNT_W'(old_pos) >= cnt_rdata) begin
                           rsp_status_in = bisr_pkg::STATUS_BAD_INDEX;
                        end else begin
                           // Fetch the old bucket's last entry; it fills the vacated slot.
                           state_in     = ST_MOVE1;
                           rsp_valid_in = rsp_valid_ff && rsp_stall;
                           bk_re        = 1'b1;
                           bk_raddr     = {old_cls, ID_W'(cnt_rdata - CNT_W'(1))};
                           old_in       = old_cls;
                           opos_in      = old_pos;
                           ocnt_in      = cnt_rdata;
                        end
                     end
                     bisr_pkg::OP_PICK, bisr_pkg::OP_LOOKUP: begin
                        if (cnt_ff == '0) begin
                           rsp_cnt_in    = '0;
                           rsp_status_in = bisr_pkg::STATUS_EMPTY;
                        end else if (op_ff == bisr_pkg::OP_LOOKUP
                                     && CNT_W'(pos_ff) >= cnt_ff) begin
                           rsp_status_in = bisr_pkg::STATUS_BAD_INDEX;
                        end else begin
                           state_in     = ST_RDATA;
                           rsp_valid_in = rsp_valid_ff && rsp_stall;
                           bk_re        = 1'b1;
                           bk_raddr     = (op_ff == bisr_pkg::OP_PICK) ? {cls_ff, pick_pos}
                                                                       : {cls_ff, pos_ff};
                        end
                     end
                     default: begin
                        // Count: the bucket size alone.
                     end
                  endcase
               end
            end
         end
         ST_RDATA: begin
            if (out_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_elem_in   = bk_rdata_ff;
               rsp_cnt_in    = cnt_ff;
               rsp_status_in = bisr_pkg::STATUS_OK;
            end
         end
         ST_MOVE1: begin
            if (out_free) begin
               state_in  = ST_MOVE2;
               bk_we     = 1'b1;
               bk_waddr  = {old_ff, opos_ff};
               bk_wdata  = back_id;
               cnt_we    = 1'b1;
               cnt_waddr = old_ff;
               cnt_wdata = ocnt_ff - CNT_W'(1);
               if (CNT_W'(back_id) < CNT_W'(MAX_ELEMENTS)) begin
                  elem_we    = 1'b1;
                  elem_waddr = back_id;
                  elem_wdata = {old_ff, opos_ff};
               end
            end
         end
         ST_MOVE2: begin
            if (out_free) begin
               // The count read here already reflects the removal written in ST_MOVE1.
               state_in      = ST_IDLE;
               elem_we       = 1'b1;
               elem_waddr    = eid_ff;
               elem_wdata    = {cls_ff, cnt_rdata[ID_W-1:0]};
               bk_we         = 1'b1;
               bk_waddr      = {cls_ff, cnt_rdata[ID_W-1:0]};
               bk_wdata      = eid_ff;
               cnt_we        = 1'b1;
               cnt_waddr     = cls_ff;
               cnt_wdata     = cnt_rdata + CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_elem_in   = eid_ff;
               rsp_cnt_in    = cnt_rdata + CNT_W'(1);
               rsp_status_in = bisr_pkg::STATUS_OK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cnt_clr) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            bucket_count_ff[i] <= '0;
         end
      end else if (cnt_we) begin
         bucket_count_ff[cnt_waddr] <= cnt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_opcode;
         eid_ff <= req_element_id;
         cls_ff <= req_class_index;
         pos_ff <= req_position;
         rnd_ff <= req_random_word;
         cnt_ff <= cnt_rdata;
      end
      old_ff        <= old_in;
      opos_ff       <= opos_in;
      ocnt_ff       <= ocnt_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Element memory: class and position of each id.
   always_ff @(posedge clock) begin
      if (accept) begin
         elem_rdata_ff <= elem_mem[req_element_id];
      end
      if (elem_we) begin
         elem_mem[elem_waddr] <= elem_wdata;
      end
   end

   // Bucket memory: one row of ids per class.
   always_ff @(posedge clock) begin
      if (bk_re) begin
         bk_rdata_ff <= bucket_mem[bk_raddr];
      end
      if (bk_we) begin
         bucket_mem[bk_waddr] <= bk_wdata;
      end
   end

   `BISR_ASSERT_NOW(a_total_bound, 1'b1, total_ff <= CNT_W'(MAX_ELEMENTS))
   `BISR_ASSERT_NEXT(a_accept_exec, accept, state_ff == ST_EXEC)
   `BISR_ASSERT_NOW(a_rsp_source, $rose(rsp_valid_ff),
      $past(state_ff) == ST_EXEC || $past(state_ff) == ST_RDATA || $past(state_ff) == ST_MOVE2)
   `BISR_ASSERT_NOW(a_empty_zero, rsp_valid_ff && rsp_status_ff == bisr_pkg::STATUS_EMPTY,
      rsp_cnt_ff == '0 && rsp_elem_ff == '0)

endmodule

FILE: tb/sv/bucketed_index_set_swap_remove_tb.sv
// Self-checking testbench for the bucketed index set with swap-remove moves.
`timescale 1ns / 1ps

module bucketed_index_set_swap_remove_tb;

   localparam int MAX_ELEMENTS = bisr_pkg::DEFAULT_MAX_ELEMENTS;
   localparam int NUM_CLASSES  = bisr_pkg::DEFAULT_NUM_CLASSES;
   localparam int ID_W  = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int RND_W = bisr_pkg::RANDOM_W;

   // The two opcodes that the block does not implement.
   localparam logic [bisr_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [bisr_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

   localparam int MIXED_ITEMS = 150;
   localparam int MAX_PRINTED = 100;

   typedef struct {
      logic [bisr_pkg::OP_W-1:0] opcode;
      logic [ID_W-1:0]           element_id;
      logic [CLS_W-1:0]          class_index;
      logic [ID_W-1:0]           position;
      logic [RND_W-1:0]          random_word;
   } bucket_req_type;

   typedef struct {
      logic [ID_W-1:0]               element;
      logic [CNT_W-1:0]              count;
      logic [bisr_pkg::STATUS_W-1:0] status;
   } bucket_rsp_type;

   typedef struct {
      bucket_req_type req;
      bit             drain_first;
   } pending_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid       = 1'b0;
   logic                          req_stall;
   logic [bisr_pkg::OP_W-1:0]     req_opcode      = '0;
   logic [ID_W-1:0]               req_element_id  = '0;
   logic [CLS_W-1:0]              req_class_index = '0;
   logic [ID_W-1:0]               req_position    = '0;
   logic [RND_W-1:0]              req_random_word = '0;

   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [ID_W-1:0]               rsp_element_out;
   logic [CNT_W-1:0]              rsp_count_out;
   logic [bisr_pkg::STATUS_W-1:0] rsp_status;

   // Predicted contents of the block.
   logic [CLS_W-1:0] member_class [MAX_ELEMENTS];
   logic [ID_W-1:0]  member_slot  [MAX_ELEMENTS];
   logic [ID_W-1:0]  bucket_list  [NUM_CLASSES][MAX_ELEMENTS];
   logic [CNT_W-1:0] bucket_size  [NUM_CLASSES];
   logic [CNT_W-1:0] ids_issued;

   pending_req_type pending_reqs[$];
   bucket_rsp_type  expected_responses[$];
   pending_req_type next_item;
   bucket_req_type  presented_req;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int error_count        = 0;
   int gen_total          = 0;

   bucketed_index_set_swap_remove #(
      .MAX_ELEMENTS(MAX_ELEMENTS),
      .NUM_CLASSES (NUM_CLASSES)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_element_id (req_element_id),
      .req_class_index(req_class_index),
      .req_position   (req_position),
      .req_random_word(req_random_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_element_out(rsp_element_out),
      .rsp_count_out  (rsp_count_out),
      .rsp_status     (rsp_status)
   );

   always #1 clock = ~clock;

   // Applies one request to the predicted state and returns the response it should give.
   function automatic bucket_rsp_type predict_bucket_response(bucket_req_type r);
      bucket_rsp_type          o;
      logic [CNT_W-1:0]        cnt;
      logic [CNT_W-1:0]        old_cnt;
      logic [CLS_W-1:0]        old_cls;
      logic [ID_W-1:0]         old_pos;
      logic [ID_W-1:0]         tail_id;
      logic [CNT_W+RND_W-1:0]  scaled;
      o.element = '0;
      o.count   = '0;
      o.status  = bisr_pkg::STATUS_OK;
      cnt = bucket_size[r.class_index];
      case (r.opcode)
         bisr_pkg::OP_CLEAR: begin
            foreach (bucket_size[c]) bucket_size[c] = '0;
            ids_issued = '0;
         end
         bisr_pkg::OP_INSERT: begin
            if (ids_issued >= MAX_ELEMENTS || cnt >= MAX_ELEMENTS) begin
               o.count  = cnt;
               o.status = bisr_pkg::STATUS_FULL;
            end else begin
               o.element = ids_issued[ID_W-1:0];
               member_class[o.element] = r.class_index;
               member_slot[o.element]  = cnt[ID_W-1:0];
               bucket_list[r.class_index][cnt[ID_W-1:0]] = o.element;
               bucket_size[r.class_index] = cnt + 1'b1;
               ids_issued = ids_issued + 1'b1;
               o.count = cnt + 1'b1;
            end
         end
         bisr_pkg::OP_MOVE: begin
            o.count  = cnt;
            o.status = bisr_pkg::STATUS_BAD_INDEX;
            if (r.element_id < ids_issued) begin
               old_cls = member_class[r.element_id];
               old_pos = member_slot[r.element_id];
               old_cnt = bucket_size[old_cls];
               if (old_cnt != 0 && old_pos < old_cnt) begin
                  // The last entry of the old bucket fills the hole.
                  tail_id = bucket_list[old_cls][old_cnt - 1'b1];
                  bucket_list[old_cls][old_pos] = tail_id;
                  member_slot[tail_id] = old_pos;
                  bucket_size[old_cls] = old_cnt - 1'b1;
                  cnt = bucket_size[r.class_index];
                  member_class[r.element_id] = r.class_index;
                  member_slot[r.element_id]  = cnt[ID_W-1:0];
                  bucket_list[r.class_index][cnt[ID_W-1:0]] = r.element_id;
                  bucket_size[r.class_index] = cnt + 1'b1;
                  o.element = r.element_id;
                  o.count   = cnt + 1'b1;
                  o.status  = bisr_pkg::STATUS_OK;
               end
            end
         end
         bisr_pkg::OP_PICK: begin
            if (cnt == 0) begin
               o.status = bisr_pkg::STATUS_EMPTY;
            end else begin
               scaled    = r.random_word * cnt;
               o.element = bucket_list[r.class_index][scaled[RND_W +: ID_W]];
               o.count   = cnt;
            end
         end
         bisr_pkg::OP_LOOKUP: begin
            if (cnt == 0) begin
               o.status = bisr_pkg::STATUS_EMPTY;
            end else if (r.position >= cnt) begin
               o.count  = cnt;
               o.status = bisr_pkg::STATUS_BAD_INDEX;
            end else begin
               o.element = bucket_list[r.class_index][r.position];
               o.count   = cnt;
            end
         end
         bisr_pkg::OP_COUNT: o.count = cnt;
         default: o.status = bisr_pkg::STATUS_BAD_INDEX;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic queue_req(input logic [bisr_pkg::OP_W-1:0] op, input int eid, input int cls,
                            input int pos, input int rnd, input bit drain_first);
      pending_req_type item;
      item.req.opcode      = op;
      item.req.element_id  = ID_W'(eid);
      item.req.class_index = CLS_W'(cls);
      item.req.position    = ID_W'(pos);
      item.req.random_word = RND_W'(rnd);
      item.drain_first     = drain_first;
      pending_reqs = {pending_reqs, item};
      if (op == bisr_pkg::OP_CLEAR) gen_total = 0;
      else if (op == bisr_pkg::OP_INSERT && gen_total < MAX_ELEMENTS) gen_total++;
   endtask

   // Mostly valid ids and positions so that moves and lookups reach their main path.
   task automatic queue_random_req(input int insert_pct, input bit allow_clear,
                                   input bit drain_first);
      int                        roll;
      int                        eid;
      int                        cls;
      int                        pos;
      int                        rnd;
      logic [bisr_pkg::OP_W-1:0] op;
      eid = $urandom_range(0, MAX_ELEMENTS - 1);
      pos = $urandom_range(0, MAX_ELEMENTS - 1);
      rnd = $urandom_range(0, (1 << RND_W) - 1);
      cls = ($urandom_range(0, 99) < 50) ? $urandom_range(0, 3)
                                          : $urandom_range(0, NUM_CLASSES - 1);
      if ($urandom_range(0, 99) < insert_pct) begin
         op = bisr_pkg::OP_INSERT;
      end else begin
         roll = $urandom_range(0, 99);
         if (allow_clear && roll < 2) op = bisr_pkg::OP_CLEAR;
         else if (roll < 40) op = bisr_pkg::OP_MOVE;
         else if (roll < 65) op = bisr_pkg::OP_PICK;
         else if (roll < 88) op = bisr_pkg::OP_LOOKUP;
         else if (roll < 96) op = bisr_pkg::OP_COUNT;
         else op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
      end
      if (op == bisr_pkg::OP_MOVE && gen_total > 0 && $urandom_range(0, 99) < 93)
         eid = $urandom_range(0, gen_total - 1);
      if (op == bisr_pkg::OP_LOOKUP && $urandom_range(0, 99) < 80)
         pos = $urandom_range(0, gen_total / 6 + 1);
      queue_req(op, eid, cls, pos, rnd, drain_first || ($urandom_range(0, 199) == 0));
   endtask

   task automatic wait_until_idle();
      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_responses.size() > 0);
      repeat (8) @(posedge clock);
   endtask

   // Driver: holds each transaction until accepted, then presents the next one or idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_responses = {expected_responses, predict_bucket_response(presented_req)};
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct &&
                !(pending_reqs[0].drain_first && expected_responses.size() > 0)) begin
               next_item       = pending_reqs.pop_front();
               presented_req   = next_item.req;
               req_valid       <= 1'b1;
               req_opcode      <= next_item.req.opcode;
               req_element_id  <= next_item.req.element_id;
               req_class_index <= next_item.req.class_index;
               req_position    <= next_item.req.position;
               req_random_word <= next_item.req.random_word;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted response against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("response arrived with nothing expected");
            end else begin
               if (rsp_element_out !== expected_responses[0].element)
                  report_mismatch($sformatf("element_out %0d, expected %0d",
                                  rsp_element_out, expected_responses[0].element));
               if (rsp_count_out !== expected_responses[0].count)
                  report_mismatch($sformatf("count_out %0d, expected %0d",
                                  rsp_count_out, expected_responses[0].count));
               if (rsp_status !== expected_responses[0].status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                  rsp_status, expected_responses[0].status));
               void'(expected_responses.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   initial begin
      int send_pct[4] = '{0, 48, 0, 14};
      int recv_pct[4] = '{0, 0, 48, 14};
      foreach (bucket_size[c]) bucket_size[c] = '0;
      ids_issued = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty buckets, unknown ids, extremes of the pick fraction,
      // swap-remove, a move into the same class, unused opcodes and clear.
      queue_req(bisr_pkg::OP_COUNT,     0,    0,    0,      0, 0);
      queue_req(bisr_pkg::OP_PICK,      0,    3,    0,  65535, 0);
      queue_req(bisr_pkg::OP_LOOKUP,    0,    3,    0,      0, 0);
      queue_req(bisr_pkg::OP_MOVE,      0,    5,    0,      0, 0);
      queue_req(bisr_pkg::OP_INSERT,    0,    0,    0,      0, 0);
      queue_req(bisr_pkg::OP_INSERT, 1023,   15, 1023,  65535, 0);
      queue_req(bisr_pkg::OP_INSERT,    0,   15,    0,      0, 0);
      queue_req(bisr_pkg::OP_INSERT,    0,   15,    0,      0, 0);
      queue_req(bisr_pkg::OP_LOOKUP,    0,   15,    0,      0, 0);
      queue_req(bisr_pkg::OP_LOOKUP,    0,   15, 1023,      0, 0);
      queue_req(bisr_pkg::OP_PICK,      0,   15,    0,      0, 0);
      queue_req(bisr_pkg::OP_PICK,      0,   15,    0,  65535, 0);
      queue_req(bisr_pkg::OP_MOVE,      1,   15,    0,      0, 0);
      queue_req(bisr_pkg::OP_LOOKUP,    0,   15,    0,      0, 0);
      queue_req(bisr_pkg::OP_LOOKUP,    0,   15,    2,      0, 0);
      queue_req(bisr_pkg::OP_MOVE,      2,    0,    0,      0, 0);
      queue_req(bisr_pkg::OP_MOVE,   1023,    0,    0,      0, 0);
      queue_req(bisr_pkg::OP_COUNT,     0,   15,    0,      0, 0);
      queue_req(OP_UNUSED_LO,        1023,   15, 1023,  65535, 0);
      queue_req(OP_UNUSED_HI,        1023,   15, 1023,  65535, 0);
      queue_req(bisr_pkg::OP_CLEAR,  1023,   15, 1023,  65535, 0);
      queue_req(bisr_pkg::OP_COUNT,     0,   15,    0,      0, 0);
      queue_req(bisr_pkg::OP_INSERT,    0,    7,    0,      0, 0);
      wait_until_idle();

      // Insert-heavy phases so that the table fills within the item budget.
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct    = send_pct[ph];
         receiver_stall_pct = recv_pct[ph];
         for (int i = 0; i < MIXED_ITEMS; i++) queue_random_req(90, ph == 0, i == 75);
         // The last phase also fills the table and keeps inserting into a full one.
         if (ph == 3) begin
            while (gen_total < MAX_ELEMENTS) queue_random_req(100, 0, 0);
            for (int i = 0; i < 20; i++) queue_random_req(50, 0, 0);
         end
         wait_until_idle();
      end

      if (error_count == 0) begin
         $display("bucketed_index_set_swap_remove verification clean");
      end else begin
         $display("bucketed_index_set_swap_remove verification failed");
      end
      $finish;
   end

   initial begin
      #800000;
      $display("bucketed_index_set_swap_remove verification failed");
      $finish;
   end

endmodule
